>>> rtl/core/tfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_pkg
// Types and constants shared by the telemetry frame receiver modules.
// ----------------------------------------------------------------------------
package tfr_pkg;

  localparam int MAX_FRAME = 32;
  localparam int CAP_LEN   = 14;
  localparam int POS_W     = 8;
  localparam int CAP_IDX_W = $clog2(CAP_LEN);

  localparam logic [7:0] HDR_BYTE    = 8'hAA;
  localparam logic [7:0] FN_ATTITUDE = 8'h01;
  localparam logic [7:0] FN_STATUS   = 8'h05;
  localparam logic [7:0] RETRY_RESET = 8'd10;
  localparam int         UNLOCK_BIT  = 3;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_ARM  = 1'b1;

  localparam logic [2:0] ST_ATTITUDE = 3'd0;
  localparam logic [2:0] ST_STATUS   = 3'd1;
  localparam logic [2:0] ST_IGNORED  = 3'd2;
  localparam logic [2:0] ST_CSUM_BAD = 3'd3;
  localparam logic [2:0] ST_HDR_BAD  = 3'd4;

  localparam logic [1:0] CONF_NONE = 2'd0;
  localparam logic [1:0] CONF_OK   = 2'd1;
  localparam logic [1:0] CONF_FAIL = 2'd2;

  typedef logic [CAP_LEN-1:0][7:0] frame_bytes_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] expected_flags;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] height;
    logic signed [15:0] battery;
    logic [7:0]         craft_kind;
    logic [7:0]         rc_count;
    logic [15:0]        sensor_flags;
    logic [15:0]        set_flags;
    logic [1:0]         confirm;
    logic               unlocked;
  } out_t;

  typedef struct packed {
    logic       fire;
    logic       cmd;
    logic [7:0] data_byte;
    logic       last_byte;
  } step_t;

  typedef struct packed {
    logic [7:0]   sum;
    frame_bytes_t bytes;
  } frame_view_t;

  typedef struct packed {
    logic        arm;
    logic [15:0] expected_flags;
    logic        check;
    logic [15:0] set_word;
  } confirm_evt_t;

endpackage

>>> rtl/core/tfr_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_capture
// Running byte sum, byte position and capture of the first 14 frame bytes.
// ----------------------------------------------------------------------------
module tfr_capture import tfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  step_t       step,
  output frame_view_t view
);

  logic [7:0]           sum;
  logic [POS_W-1:0]     pos;
  frame_bytes_t         bytes;
  logic                 pos_in_cap;
  logic [CAP_IDX_W-1:0] cap_idx;

  assign pos_in_cap = pos < POS_W'(CAP_LEN);
  assign cap_idx    = pos[CAP_IDX_W-1:0];

  always_comb begin
    view.sum   = sum;
    view.bytes = bytes;
    if (pos_in_cap) begin
      view.bytes[cap_idx] = step.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      pos   <= '0;
      bytes <= '0;
    end else if (step.fire && step.cmd == CMD_BYTE) begin
      if (step.last_byte) begin
        sum   <= '0;
        pos   <= '0;
        bytes <= '0;
      end else if (pos < POS_W'(MAX_FRAME - 1)) begin
        if (pos_in_cap) begin
          bytes[cap_idx] <= step.data_byte;
        end
        sum <= sum + step.data_byte;
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/tfr_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_decode
// Checksum, header and function check and field extraction for a frame.
// ----------------------------------------------------------------------------
module tfr_decode import tfr_pkg::*; (
  input  frame_view_t view,
  input  logic [7:0]  csum,
  output out_t        res
);

  frame_bytes_t b;

  assign b = view.bytes;

  always_comb begin
    res = '0;
    if (view.sum != csum) begin
      res.status = ST_CSUM_BAD;
    end else if (b[0] != HDR_BYTE || b[1] != HDR_BYTE) begin
      res.status = ST_HDR_BAD;
    end else if (b[2] == FN_ATTITUDE) begin
      res.status  = ST_ATTITUDE;
      res.angle_x = {b[4], b[5]};
      res.angle_y = {b[6], b[7]};
      res.angle_z = {b[8], b[9]};
      res.height  = {b[10], b[11], b[12], b[13]};
    end else if (b[2] == FN_STATUS) begin
      res.status       = ST_STATUS;
      res.battery      = {b[4], b[5]};
      res.craft_kind   = b[8];
      res.rc_count     = b[9];
      res.sensor_flags = {b[10], b[11]};
      res.set_flags    = {b[12], b[13]};
      res.unlocked     = b[11][UNLOCK_BIT];
    end else begin
      res.status = ST_IGNORED;
    end
  end

endmodule

>>> rtl/core/tfr_confirm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_confirm
// Pending setting confirmation: expected word, mismatch count, retry limit.
// ----------------------------------------------------------------------------
module tfr_confirm import tfr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write_en,
  input  logic [7:0]   cfg_write_data,
  input  confirm_evt_t evt,
  output logic [1:0]   confirm
);

  logic [7:0]  retry_limit;
  logic        pending;
  logic [15:0] expected_word;
  logic [7:0]  mismatch_count;
  logic        pending_next;
  logic [7:0]  mismatch_next;
  logic [7:0]  mismatch_inc;

  assign mismatch_inc = mismatch_count + 1'b1;

  always_comb begin
    confirm       = CONF_NONE;
    pending_next  = pending;
    mismatch_next = mismatch_count;
    if (evt.arm) begin
      pending_next  = 1'b1;
      mismatch_next = '0;
    end else if (evt.check && pending) begin
      if (evt.set_word == expected_word) begin
        confirm       = CONF_OK;
        pending_next  = 1'b0;
        mismatch_next = '0;
      end else if (mismatch_inc >= retry_limit) begin
        confirm       = CONF_FAIL;
        pending_next  = 1'b0;
        mismatch_next = '0;
      end else begin
        mismatch_next = mismatch_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit    <= RETRY_RESET;
      pending        <= 1'b0;
      expected_word  <= '0;
      mismatch_count <= '0;
    end else begin
      if (cfg_write_en) begin
        retry_limit <= cfg_write_data;
      end
      if (evt.arm) begin
        expected_word <= evt.expected_flags;
      end
      pending        <= pending_next;
      mismatch_count <= mismatch_next;
    end
  end

endmodule

>>> rtl/core/telemetry_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_receiver_unit
// Byte-serial telemetry frame parser with checksum and setting confirmation.
//
// Input channel (item_valid / item_stall / item): one transfer per frame byte
// (cmd byte, last_byte marks the checksum) or one arm transfer (cmd arm) that
// loads the expected settings word for a confirmation wait.
// Result channel (result_valid / result_stall / result): one transfer per
// frame, after its last byte; arm transfers and other bytes give none.
// Config: cfg_write_en / cfg_write_data write the retry limit; write only
// while the block is idle.
// The last byte passes through the input register and then the result
// register before result_valid rises.
// Throughput: one item per cycle while the result side is not stalled,
// set by the single input register feeding the result register.
// Reset clears the frame state, the pending wait and sets the retry limit
// to 10. A stalled result holds in the result register; the input keeps
// accepting until the input register is full behind it.
// ----------------------------------------------------------------------------
module telemetry_frame_receiver_unit import tfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  in_t        item,
  output logic       result_valid,
  input  logic       result_stall,
  output out_t       result,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data
);

  logic         s1_valid;
  in_t          s1_item;
  logic         adv;
  logic         fire;
  logic         res_fire;
  step_t        step;
  frame_view_t  view;
  out_t         dec;
  out_t         result_next;
  confirm_evt_t evt;
  logic [1:0]   confirm;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = s1_valid && !adv;
  assign fire       = s1_valid && adv;
  assign res_fire   = fire && s1_item.cmd == CMD_BYTE && s1_item.last_byte;

  assign step.fire      = fire;
  assign step.cmd       = s1_item.cmd;
  assign step.data_byte = s1_item.data_byte;
  assign step.last_byte = s1_item.last_byte;

  tfr_capture u_capture (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .view (view)
  );

  tfr_decode u_decode (
    .view (view),
    .csum (s1_item.data_byte),
    .res  (dec)
  );

  assign evt.arm            = fire && s1_item.cmd == CMD_ARM;
  assign evt.expected_flags = s1_item.expected_flags;
  assign evt.check          = res_fire && dec.status == ST_STATUS;
  assign evt.set_word       = dec.set_flags;

  tfr_confirm u_confirm (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .evt            (evt),
    .confirm        (confirm)
  );

  always_comb begin
    result_next         = dec;
    result_next.confirm = confirm;
  end

  // hold the input register while it is full and the result side is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_fire) begin
      result <= result_next;
    end
  end

endmodule
